>>> rtl/hss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hss_pkg: heater start-up sequencer shared definitions
// Phase, message, autotune command and register index codes, beat widths.
// ----------------------------------------------------------------------------
package hss_pkg;

   localparam int unsigned REQ_DATA_W = 24;
   localparam int unsigned RSP_DATA_W = 64;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned PERMILLE_DIV = 1000;

   typedef enum logic [2:0] {
      PH_START = 3'd0,
      PH_TEST  = 3'd1,
      PH_SOFT  = 3'd2,
      PH_TSN   = 3'd3,
      PH_WAIT  = 3'd4,
      PH_DONE  = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      MSG_STARTING = 3'd0,
      MSG_MANUAL   = 3'd1,
      MSG_SOFT     = 3'd2,
      MSG_WAIT_AT  = 3'd3,
      MSG_WAITING  = 3'd4,
      MSG_KEEP     = 3'd5,
      MSG_BLANK    = 3'd6
   } msg_type;

   typedef enum logic [1:0] {
      AT_NONE  = 2'd0,
      AT_START = 2'd1,
      AT_OFF   = 2'd2
   } at_cmd_type;

   typedef enum logic [2:0] {
      CSR_SST_TIME  = 3'd0,
      CSR_SST_THR   = 3'd1,
      CSR_AT_THR    = 3'd2,
      CSR_PERMILLE  = 3'd3,
      CSR_SETPOINT  = 3'd4,
      CSR_BAND      = 3'd5,
      CSR_INTEGRAL  = 3'd6,
      CSR_DERIV     = 3'd7
   } csr_idx_type;

endpackage

>>> rtl/heater_startup_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heater_startup_sequencer_top: start-up sequencer for a hot-runner heater
// One request beat per one-second tick gives one response beat with the
// phase, PID default load request, autotune command and status message.
// ----------------------------------------------------------------------------
// Each req beat yields exactly one rsp beat, in order. A beat goes through an
// input register and a result register, and rsp_tvalid is driven straight from
// the result register, which only loads while it is empty or rsp_tready is high.
// A new beat is accepted every cycle as long as rsp_tready keeps up. The
// autotune trigger compares measured_temp*1000 against autotune_permille*setpoint,
// the product being registered from the control registers, so write registers
// with the block idle. After reset the sequencer spends START_DELAY+1 ticks in
// the start-delay phase before testing the temperature.
module heater_startup_sequencer_top #(
   parameter int unsigned START_DELAY = 30
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // measured_temp[15:0], sensor_fault[16], manual_active[17], autotune_active[18],
   // standby_pin[19], zero[23:20]
   input  logic [hss_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // phase[2:0], load_defaults[3], band_out[19:4], integral_out[35:20],
   // derivative_out[51:36], autotune_cmd[53:52], force_manual[54],
   // message_code[57:55], zero[63:58]
   output logic [hss_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_wr_en,
   input  logic [hss_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hss_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import hss_pkg::*;

   localparam int unsigned DCNT_W = (START_DELAY < 2) ? 1 : $clog2(START_DELAY + 1);

   // control registers
   logic        [13:0] sst_time_ff;
   logic signed [15:0] sst_thr_ff;
   logic signed [15:0] at_thr_ff;
   logic        [9:0]  permille_ff;
   logic signed [15:0] setpoint_ff;
   logic        [15:0] band_ff;
   logic        [15:0] integral_ff;
   logic        [15:0] deriv_ff;
   logic signed [27:0] lim_prod_ff;
   logic signed [27:0] lim_prod_in;

   // input stage
   logic               in_valid_ff;
   logic signed [15:0] temp_ff;
   logic               fault_ff;
   logic               manual_ff;
   logic               at_active_ff;
   logic               standby_ff;

   // sequencer state
   phase_type           phase_ff, phase_in;
   logic [DCNT_W-1:0]   delay_count_ff, delay_count_in;
   logic [13:0]         soft_count_ff, soft_count_in;

   // result stage
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic               advance;
   logic               req_beat;
   logic signed [27:0] temp_k;
   logic               temp_above;
   logic               load;
   logic               at_start;
   logic               fault_eff;
   logic               man_eff;
   logic               force_req;
   logic               at_act;
   at_cmd_type         cmd;
   msg_type            msg;
   logic               at_below;
   logic               sst_below;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_beat   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sst_time_ff <= '0;
         sst_thr_ff  <= '0;
         at_thr_ff   <= '0;
         permille_ff <= '0;
         setpoint_ff <= '0;
         band_ff     <= '0;
         integral_ff <= '0;
         deriv_ff    <= '0;
         lim_prod_ff <= '0;
      end else begin
         lim_prod_ff <= lim_prod_in;
         if (csr_wr_en) begin
            unique case (csr_idx_type'(csr_index))
               CSR_SST_TIME: sst_time_ff <= csr_wdata[13:0];
               CSR_SST_THR:  sst_thr_ff  <= csr_wdata;
               CSR_AT_THR:   at_thr_ff   <= csr_wdata;
               CSR_PERMILLE: permille_ff <= csr_wdata[9:0];
               CSR_SETPOINT: setpoint_ff <= csr_wdata;
               CSR_BAND:     band_ff     <= csr_wdata;
               CSR_INTEGRAL: integral_ff <= csr_wdata;
               CSR_DERIV:    deriv_ff    <= csr_wdata;
               default:      ;
            endcase
         end
      end
   end

   assign lim_prod_in = $signed({18'd0, permille_ff})
                        * $signed({{12{setpoint_ff[15]}}, setpoint_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_beat) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         temp_ff      <= req_tdata[15:0];
         fault_ff     <= req_tdata[16];
         manual_ff    <= req_tdata[17];
         at_active_ff <= req_tdata[18];
         standby_ff   <= req_tdata[19];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_START;
         delay_count_ff <= '0;
         soft_count_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (advance) begin
            phase_ff       <= phase_in;
            delay_count_ff <= delay_count_in;
            soft_count_ff  <= soft_count_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // temp > trunc(P/1000) rewritten without a divider
   assign temp_k     = $signed({{12{temp_ff[15]}}, temp_ff}) * 28'sd1000;
   assign temp_above = lim_prod_ff[27] ? (temp_k - 28'sd1000 >= lim_prod_ff)
                                       : (temp_k > lim_prod_ff);
   assign at_below   = (at_thr_ff != 16'sd0) && (temp_ff < at_thr_ff);
   assign sst_below  = (sst_thr_ff != 16'sd0) && (temp_ff < sst_thr_ff);

   always_comb begin
      phase_in       = phase_ff;
      delay_count_in = delay_count_ff;
      soft_count_in  = soft_count_ff;
      load           = 1'b0;
      at_start       = 1'b0;
      fault_eff      = fault_ff;
      cmd            = AT_NONE;

      unique case (phase_ff)
         PH_START: begin
            fault_eff = 1'b0;
            if (delay_count_ff < DCNT_W'(START_DELAY)) begin
               delay_count_in = delay_count_ff + 1'b1;
            end else begin
               phase_in = PH_TEST;
            end
         end
         PH_TEST: begin
            load     = at_below;
            phase_in = sst_below ? PH_SOFT : PH_TSN;
         end
         PH_SOFT: begin
            if (soft_count_ff < sst_time_ff) begin
               soft_count_in = soft_count_ff + 1'b1;
            end else begin
               phase_in = PH_TSN;
            end
         end
         PH_TSN: begin
            phase_in = at_below ? PH_WAIT : PH_DONE;
         end
         PH_WAIT: begin
            if (temp_above) begin
               at_start = 1'b1;
               phase_in = PH_DONE;
            end
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase

      force_req = fault_eff && !manual_ff;
      man_eff   = manual_ff || fault_eff;
      at_act    = at_active_ff || at_start;

      if (man_eff) begin
         if (at_act) begin
            cmd = AT_OFF;
         end
      end else if (at_start) begin
         cmd = AT_START;
      end

      if (phase_in == PH_START) begin
         msg = MSG_STARTING;
      end else if (man_eff) begin
         phase_in = PH_DONE;
         msg      = MSG_MANUAL;
      end else if (phase_in == PH_SOFT) begin
         msg = MSG_SOFT;
      end else if (phase_in == PH_WAIT) begin
         msg = MSG_WAIT_AT;
      end else if (!standby_ff) begin
         msg = MSG_WAITING;
      end else if (at_act) begin
         msg = MSG_KEEP;
      end else begin
         msg = MSG_BLANK;
      end

      rsp_data_in = {6'd0, msg, force_req, cmd,
                     load ? deriv_ff    : 16'd0,
                     load ? integral_ff : 16'd0,
                     load ? band_ff     : 16'd0,
                     load, phase_in};
   end

endmodule

>>> rtl/hss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hss_checker: port-level checks for the heater start-up sequencer
// Watches response beats for consistent fields and a sticky done phase.
// ----------------------------------------------------------------------------
module hss_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [hss_pkg::REQ_DATA_W-1:0]  req_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [hss_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                            csr_wr_en,
   input logic [hss_pkg::CSR_IDX_W-1:0]   csr_index,
   input logic [hss_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import hss_pkg::*;

   logic rsp_beat;
   logic seen_done_ff;
   logic unused_ok;

   assign rsp_beat  = rsp_tvalid && rsp_tready;
   assign unused_ok = ^{req_tvalid, req_tready, req_tdata, csr_wr_en, csr_index, csr_wdata};

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_done_ff <= 1'b0;
      end else if (rsp_beat && (rsp_tdata[2:0] == PH_DONE) && !unused_ok | unused_ok) begin
         seen_done_ff <= seen_done_ff || (rsp_beat && (rsp_tdata[2:0] == PH_DONE));
      end
   end

   // done phase holds until reset
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && seen_done_ff |-> rsp_tdata[2:0] == PH_DONE)
      else $error("phase left done");

   a_force_msg: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && rsp_tdata[54] |-> rsp_tdata[57:55] == MSG_MANUAL)
      else $error("forced manual without manual message");

   a_no_load_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && !rsp_tdata[3] |-> rsp_tdata[51:4] == 48'd0)
      else $error("defaults present without load request");

   a_start_done: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && rsp_tdata[53:52] == AT_START |-> rsp_tdata[2:0] == PH_DONE)
      else $error("autotune start outside done phase");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response beat changed");

endmodule

bind heater_startup_sequencer_top hss_checker u_hss_checker (.*);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for heater_startup_sequencer_top
// Walks the sequencer once through start delay, temperature test, soft start,
// autotune wait and done, retuning the registers between stretches while the
// block is idle. A scoreboard class predicts every response beat from the
// accepted tick beats and compares it field by field, with random idling on
// both streams, a long response hold-off and drain pauses.
// ----------------------------------------------------------------------------
module testbench;
   import hss_pkg::*;

   localparam int START_DELAY    = 30;
   localparam int IDLE_GAP       = 4;
   localparam int TAIL_CYCLES    = 10;
   localparam int LONG_HOLD      = 80;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int WAIT_SETTINGS  = 6;
   localparam int WAIT_TICKS     = 50;
   localparam int DONE_TICKS     = 260;

   typedef struct {
      logic signed [15:0] temp;
      logic               fault;
      logic               manual;
      logic               at_active;
      logic               standby;
   } heater_tick_type;

   typedef struct {
      phase_type   phase;
      logic        load;
      logic [15:0] band;
      logic [15:0] integ;
      logic [15:0] deriv;
      at_cmd_type  cmd;
      logic        force_manual;
      msg_type     msg;
   } step_result_type;

   class startup_scoreboard;
      bit [13:0]          soft_time;
      logic signed [15:0] soft_thr;
      logic signed [15:0] tune_thr;
      bit [9:0]           permille;
      logic signed [15:0] setpoint;
      logic [15:0]        band;
      logic [15:0]        integ;
      logic [15:0]        deriv;
      phase_type          phase;
      int                 delay_cnt;
      bit [13:0]          soft_cnt;
      step_result_type    expected_q[$];
      int                 mismatches;
      int                 beats;

      function new();
         soft_time  = '0;
         soft_thr   = '0;
         tune_thr   = '0;
         permille   = '0;
         setpoint   = '0;
         band       = '0;
         integ      = '0;
         deriv      = '0;
         phase      = PH_START;
         delay_cnt  = 0;
         soft_cnt   = '0;
         mismatches = 0;
         beats      = 0;
      endfunction

      function void write_reg(csr_idx_type idx, logic [15:0] value);
         case (idx)
            CSR_SST_TIME: soft_time = value[13:0];
            CSR_SST_THR:  soft_thr  = value;
            CSR_AT_THR:   tune_thr  = value;
            CSR_PERMILLE: permille  = value[9:0];
            CSR_SETPOINT: setpoint  = value;
            CSR_BAND:     band      = value;
            CSR_INTEGRAL: integ     = value;
            CSR_DERIV:    deriv     = value;
            default: ;
         endcase
      endfunction

      function longint autotune_limit();
         return (longint'(permille) * longint'(setpoint)) / longint'(PERMILLE_DIV);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function step_result_type advance_sequence(heater_tick_type t);
         step_result_type r;
         logic         fault;
         logic         manual;
         logic         tune_on;
         logic         tune_start;
         logic         forced;
         logic         load;
         at_cmd_type   cmd;
         msg_type      msg;
         fault      = t.fault;
         manual     = t.manual;
         tune_on    = t.at_active;
         tune_start = 1'b0;
         forced     = 1'b0;
         load       = 1'b0;
         cmd        = AT_NONE;
         case (phase)
            PH_START: begin
               fault = 1'b0;
               if (delay_cnt < START_DELAY) delay_cnt++;
               else phase = PH_TEST;
            end
            PH_TEST: begin
               load  = (tune_thr != 0) && (t.temp < tune_thr);
               phase = (soft_thr != 0 && t.temp < soft_thr) ? PH_SOFT : PH_TSN;
            end
            PH_SOFT: begin
               if (soft_cnt < soft_time) soft_cnt = soft_cnt + 1'b1;
               else phase = PH_TSN;
            end
            PH_TSN: begin
               phase = (tune_thr != 0 && t.temp < tune_thr) ? PH_WAIT : PH_DONE;
            end
            PH_WAIT: begin
               if (longint'(t.temp) > autotune_limit()) begin
                  tune_start = 1'b1;
                  phase      = PH_DONE;
               end
            end
            default: phase = PH_DONE;
         endcase
         if (fault && !manual) begin
            forced = 1'b1;
            manual = 1'b1;
         end
         if (tune_start) tune_on = 1'b1;
         if (manual) begin
            if (tune_on) begin
               cmd     = AT_OFF;
               tune_on = 1'b0;
            end
         end else if (tune_start) begin
            cmd = AT_START;
         end
         if (phase == PH_START) begin
            msg = MSG_STARTING;
         end else if (manual) begin
            phase = PH_DONE;
            msg   = MSG_MANUAL;
         end else if (phase == PH_SOFT) begin
            msg = MSG_SOFT;
         end else if (phase == PH_WAIT) begin
            msg = MSG_WAIT_AT;
         end else if (!t.standby) begin
            msg = MSG_WAITING;
         end else if (tune_on) begin
            msg = MSG_KEEP;
         end else begin
            msg = MSG_BLANK;
         end
         r.phase        = phase;
         r.load         = load;
         r.band         = load ? band  : 16'h0000;
         r.integ        = load ? integ : 16'h0000;
         r.deriv        = load ? deriv : 16'h0000;
         r.cmd          = cmd;
         r.force_manual = forced;
         r.msg          = msg;
         return r;
      endfunction

      function void note_tick(heater_tick_type t);
         expected_q.push_back(advance_sequence(t));
      endfunction

      task report(string what);
         mismatches++;
         if (mismatches <= 40) $display("[%0t] mismatch: %s", $realtime, what);
      endtask

      task cmp_field(string name, logic [15:0] got, logic [15:0] want);
         if (got !== want)
            report($sformatf("beat %0d %s got %0h expected %0h", beats, name, got, want));
      endtask

      task check_result(logic [RSP_DATA_W-1:0] d);
         step_result_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("beat %0d arrived with no tick outstanding", beats));
         end else begin
            want = expected_q.pop_front();
            cmp_field("phase", 16'(d[2:0]), 16'(want.phase));
            cmp_field("load_defaults", 16'(d[3]), 16'(want.load));
            cmp_field("band_out", d[19:4], want.band);
            cmp_field("integral_out", d[35:20], want.integ);
            cmp_field("derivative_out", d[51:36], want.deriv);
            cmp_field("autotune_cmd", 16'(d[53:52]), 16'(want.cmd));
            cmp_field("force_manual", 16'(d[54]), 16'(want.force_manual));
            cmp_field("message_code", 16'(d[57:55]), 16'(want.msg));
            cmp_field("padding", 16'(d[63:58]), 16'h0000);
         end
         beats++;
      endtask
   endclass

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = CSR_SST_TIME;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   bit                    no_idle      = 1'b0;
   bit                    hold_off_req = 1'b0;
   startup_scoreboard     sb           = new();

   heater_startup_sequencer_top #(
      .START_DELAY(START_DELAY)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic heater_tick_type random_tick();
      heater_tick_type t;
      t.temp      = 16'($urandom);
      t.fault     = 1'($urandom);
      t.manual    = 1'($urandom);
      t.at_active = 1'($urandom);
      t.standby   = 1'($urandom);
      return t;
   endfunction

   // keep the sequence alive: no fault, no manual
   function automatic heater_tick_type quiet_tick();
      heater_tick_type t;
      t        = random_tick();
      t.fault  = 1'b0;
      t.manual = 1'b0;
      return t;
   endfunction

   task automatic csr_write(input csr_idx_type idx, input logic [15:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.write_reg(idx, value);
      repeat (IDLE_GAP) @(posedge clock);
   endtask

   task automatic send_tick(input heater_tick_type t);
      int gap;
      gap = no_idle ? 0 : $urandom_range(8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, t.standby, t.at_active, t.manual, t.fault, t.temp};
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_tick(t);
   endtask

   // hold the input until every response beat is back
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (IDLE_GAP) @(posedge clock);
   endtask

   initial begin : rsp_sink
      int stall;
      wait (reset === 1'b0);
      forever begin
         if (hold_off_req) begin
            stall        = LONG_HOLD;
            hold_off_req = 1'b0;
         end else begin
            stall = no_idle ? 0 : $urandom_range(8);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         sb.check_result(rsp_tdata);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid === 1'b1 && req_tready === 1'b1) ||
             (rsp_tvalid === 1'b1 && rsp_tready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("heater_startup_sequencer_top regression: fail");
      $finish;
   end

   initial begin : stimulus
      heater_tick_type    t;
      int                 n;
      longint             cap;
      logic signed [15:0] corner_temps [4];
      int                 wait_permille [WAIT_SETTINGS];
      int                 wait_setpoint [WAIT_SETTINGS];
      corner_temps  = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF};
      wait_permille = '{1000, 0, 999, 1000, 517, 1};
      wait_setpoint = '{32767, 12345, -32767, -32768, 0, -1};
      wait_setpoint[4] = int'($signed(16'($urandom)));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      csr_write(CSR_SST_TIME, 16'd9999);
      csr_write(CSR_SST_THR, 16'h7FFF);
      csr_write(CSR_AT_THR, 16'h7FFF);
      csr_write(CSR_PERMILLE, 16'd1000);
      csr_write(CSR_SETPOINT, 16'h7FFF);
      csr_write(CSR_BAND, 16'hFFFF);
      csr_write(CSR_INTEGRAL, 16'h0000);
      csr_write(CSR_DERIV, 16'($urandom));

      // start delay: fault ignored, manual still cancels autotune
      n = 0;
      while (sb.phase == PH_START) begin
         t = random_tick();
         if (n < 4) t.temp = corner_temps[n];
         // leave the delay without manual so the sequence goes on
         if (sb.delay_cnt >= START_DELAY) t.manual = 1'b0;
         n++;
         send_tick(t);
      end

      // temperature test below both thresholds: load defaults, soft start
      t      = quiet_tick();
      t.temp = 16'sh8000;
      send_tick(t);
      repeat (8) send_tick(quiet_tick());
      drain_responses();
      csr_write(CSR_SST_TIME, 16'd12);
      while (sb.phase == PH_SOFT) send_tick(quiet_tick());

      t      = quiet_tick();
      t.temp = 16'sh7FFE;
      send_tick(t);

      // autotune wait: stay at or below the trigger level
      for (int k = 0; k < WAIT_SETTINGS; k++) begin
         drain_responses();
         csr_write(CSR_PERMILLE, 16'(wait_permille[k]));
         csr_write(CSR_SETPOINT, 16'(wait_setpoint[k]));
         cap = sb.autotune_limit();
         if (k == 0) no_idle = 1'b1;
         for (int i = 0; i < WAIT_TICKS; i++) begin
            t = quiet_tick();
            if (i == 0) t.temp = 16'(cap);
            else if (i == 1) t.temp = 16'sh8000;
            else t.temp = 16'(longint'($urandom_range(32'(cap + 32768))) - 32768);
            if (k == 0 && i == 20) hold_off_req = 1'b1;
            if (k == 0 && i == 45) no_idle = 1'b0;
            send_tick(t);
         end
      end
      t      = quiet_tick();
      t.temp = 16'(cap + 1);
      send_tick(t);

      drain_responses();
      csr_write(CSR_SST_TIME, 16'd0);
      csr_write(CSR_SST_THR, 16'h8000);
      csr_write(CSR_AT_THR, 16'h0000);
      csr_write(CSR_PERMILLE, 16'd0);
      csr_write(CSR_SETPOINT, 16'h8000);
      csr_write(CSR_BAND, 16'h0000);
      csr_write(CSR_INTEGRAL, 16'hFFFF);
      csr_write(CSR_DERIV, 16'h0000);

      for (int i = 0; i < DONE_TICKS; i++) begin
         no_idle = (i >= 100 && i < 140);
         send_tick(random_tick());
      end
      no_idle = 1'b0;

      drain_responses();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0)
         $display("heater_startup_sequencer_top regression: pass");
      else
         $display("heater_startup_sequencer_top regression: fail");
      $finish;
   end

endmodule
